[rtl/fwt_pkg.sv]
// ----------------------------------------------------------------------------
// fwt_pkg
// types and constants shared by the binary indexed tree block
// ----------------------------------------------------------------------------
package fwt_pkg;

   localparam int IDX_W  = 10;
   localparam int DATA_W = 64;
   localparam int SIZE_W = 11;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_SUM  = 2'd1;
   localparam logic [1:0] OP_LB   = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]               opcode;
      logic [IDX_W-1:0]         first_index;
      logic [IDX_W-1:0]         last_index;
      logic signed [DATA_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] total;
      logic [IDX_W-1:0]         found_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD,
      ST_SUM_HI,
      ST_SUM_LO,
      ST_LB_RD,
      ST_LB_CHK,
      ST_DONE
   } state_type;

endpackage

[rtl/fenwick_tree_prefix_sum_top.sv]
// ----------------------------------------------------------------------------
// fenwick_tree_prefix_sum_top
// binary indexed tree of signed 64-bit counts held in one synchronous ram
// a non-positive lower bound target or an unused opcode answers without touching the ram
// throughput: one transaction at a time, the next taken in the cycle after a response loads
// reset: size goes to 1024, then a clearing pass zeroes all DEPTH words of the ram
// ----------------------------------------------------------------------------
module fenwick_tree_prefix_sum_top #(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fwt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fwt_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_wdata
);
   import fwt_pkg::*;

   // node numbers run 1..DEPTH, ram address is node - 1
   localparam int AW  = $clog2(DEPTH);
   localparam int NW  = $clog2(DEPTH + 1);
   // counter width: room for node walks past n and index plus step sums
   localparam int CW  = ((NW > SIZE_W) ? NW : SIZE_W) + 2;
   localparam logic [CW-1:0] TOP_LEN = CW'(1) << $clog2(DEPTH);

   // node store
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   // control and datapath registers
   state_type         state_ff, state_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [CW-1:0]     k_ff, k_in;
   logic [CW-1:0]     wa_ff, wa_in;
   logic              pend_ff, pend_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] amt_ff, amt_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [CW-1:0]     size_ext;
   logic [CW-1:0]     n_w;
   logic [CW-1:0]     lowbit;
   logic [CW-1:0]     probe;
   logic [CW-1:0]     count_hi;
   logic [CW-1:0]     count_lo;
   logic              req_fire;

   // effective size: a size above the built depth acts as the depth
   assign size_ext = CW'(size_ff);
   assign n_w      = (size_ext > CW'(DEPTH)) ? CW'(DEPTH) : size_ext;
   assign lowbit   = k_ff & (~k_ff + CW'(1));
   assign probe    = i_ff + len_ff;

   // prefix counts clamp to the size in use
   assign count_hi = ((CW'(req_payload.last_index) + CW'(1)) > n_w) ? n_w
                   : (CW'(req_payload.last_index) + CW'(1));
   assign count_lo = (CW'(first_ff) > n_w) ? n_w : CW'(first_ff);

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // write port: clearing pass or add write-back of the node read last cycle
   assign wr_en   = (state_ff == ST_CLEAR) || ((state_ff == ST_ADD) && pend_ff);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : AW'(wa_ff - CW'(1));
   assign wr_data = (state_ff == ST_CLEAR) ? '0 : (rdata_ff + amt_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= SIZE_RESET;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      wa_ff       <= wa_in;
      acc_ff      <= acc_in;
      amt_ff      <= amt_in;
      i_ff        <= i_in;
      len_ff      <= len_in;
      first_ff    <= first_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      k_in         = k_ff;
      wa_in        = wa_ff;
      pend_in      = 1'b0;
      acc_in       = acc_ff;
      amt_in       = amt_ff;
      i_in         = i_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(k_ff - CW'(1));

      // size register, the host must write it only while idle; the block does not enforce this
      if (csr_valid && csr_ready) begin
         size_in = csr_wdata;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               acc_in   = '0;
               i_in     = '0;
               first_in = req_payload.first_index;
               amt_in   = req_payload.amount;
               unique case (req_payload.opcode)
                  OP_ADD: begin
                     k_in     = CW'(req_payload.first_index) + CW'(1);
                     state_in = ST_ADD;
                  end
                  OP_SUM: begin
                     k_in     = count_hi;
                     state_in = ST_SUM_HI;
                  end
                  OP_LB: begin
                     len_in = TOP_LEN;
                     // non-positive target answers zero at once
                     if (req_payload.amount[DATA_W-1] || (req_payload.amount == '0)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_LB_RD;
                     end
                  end
                  OP_NONE: begin
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ADD: begin
            // walk upward, one read issued per cycle, write-back in the following cycle
            if ((k_ff != '0) && (k_ff <= n_w)) begin
               rd_en   = 1'b1;
               wa_in   = k_ff;
               k_in    = k_ff + lowbit;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_SUM_HI, ST_SUM_LO: begin
            // walk downward; upper prefix adds, lower prefix subtracts
            if (pend_ff) begin
               acc_in = (state_ff == ST_SUM_HI) ? (acc_ff + rdata_ff) : (acc_ff - rdata_ff);
            end
            if (k_ff != '0) begin
               rd_en   = 1'b1;
               k_in    = k_ff - lowbit;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               if (state_ff == ST_SUM_HI) begin
                  k_in     = count_lo;
                  state_in = ST_SUM_LO;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LB_RD: begin
            // the search never probes node n, so steps at or past it are skipped
            if (len_ff == '0) begin
               state_in = ST_DONE;
            end else if (probe < n_w) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(probe - CW'(1));
               state_in = ST_LB_CHK;
            end else begin
               len_in = len_ff >> 1;
            end
         end
         ST_LB_CHK: begin
            if ($signed(rdata_ff) < $signed(amt_ff)) begin
               amt_in = amt_ff - rdata_ff;
               i_in   = probe;
            end
            len_in   = len_ff >> 1;
            state_in = ST_LB_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.total       = acc_ff;
               rsp_data_in.found_index = i_ff[IDX_W-1:0];
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   // a search probe always lies below the size in use
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LB_CHK) |-> ($past(probe) < n_w))
      else $error("lower bound probe beyond size in use");

   // reads outstanding only inside a tree walk
   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> ((state_ff == ST_ADD) || (state_ff == ST_SUM_HI) || (state_ff == ST_SUM_LO)))
      else $error("read data pending outside a walk");

   // add write-back never touches a node past the size in use
   a_add_write_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ADD) && pend_ff) |-> ((wa_ff != '0) && (wa_ff <= n_w)))
      else $error("add write outside tree");

   // the clearing pass runs right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == ST_CLEAR))
      else $error("no clearing pass after reset");
`endif

endmodule
